// File: hdl/dam_pkg.sv
// Shared types and constants for the decimal accumulator machine.
package dam_pkg;

   localparam int MEM_WORDS_DEF = 100;
   localparam int WORD_W        = 15;
   localparam int MAG_W         = 14;
   localparam int PC_W          = 7;

   // Command codes of an input beat.
   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_STEP    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // Event codes of a result beat.
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_WRITE = 2'd1;
   localparam logic [1:0] EV_HALT  = 2'd2;
   localparam logic [1:0] EV_ERROR = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_OPCODE   = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW = 3'd2;
   localparam logic [2:0] ERR_DIV_ZERO = 3'd3;
   localparam logic [2:0] ERR_RANGE    = 3'd4;
   localparam logic [2:0] ERR_NEG_EXP  = 3'd5;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FETCH,
      ST_DECODE,
      ST_ADDR,
      ST_OPREAD,
      ST_EXEC,
      ST_ITER,
      ST_FINISH
   } dam_state_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_DISPATCH,
      DP_SPLIT,
      DP_DECODE,
      DP_ADDR,
      DP_OPREAD,
      DP_EXEC,
      DP_ITER,
      DP_PUBLISH
   } dam_dpop_type;

   // Status returned by the datapath.
   typedef struct packed {
      logic [1:0] cmd;
      logic       halted;
      logic       pc_oob;
      logic       busy;
   } dam_sts_type;

endpackage

// File: hdl/dam_ctrl.sv
// Controller state machine of the decimal accumulator machine.
module dam_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dam_pkg::dam_sts_type  sts,
   output dam_pkg::dam_dpop_type dp_op
);
   import dam_pkg::*;

   dam_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dp_op        = DP_NOP;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_op    = DP_CAPTURE;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            dp_op = DP_DISPATCH;
            if (sts.cmd == CMD_STEP && !sts.halted && !sts.pc_oob) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FETCH: begin
            dp_op    = DP_SPLIT;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            dp_op    = DP_DECODE;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            dp_op    = DP_ADDR;
            state_in = ST_OPREAD;
         end
         ST_OPREAD: begin
            dp_op    = DP_OPREAD;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            dp_op    = DP_EXEC;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (sts.busy) begin
               dp_op = DP_ITER;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_op        = DP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/dam_dp.sv
// Datapath of the decimal accumulator machine: memory, registers and arithmetic.
module dam_dp #(
   parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dam_pkg::dam_dpop_type dp_op,
   input  logic [1:0]            req_command,
   input  logic [6:0]            req_address,
   input  logic signed [14:0]    req_value,
   output dam_pkg::dam_sts_type  sts,
   output logic [1:0]            rsp_event_res,
   output logic signed [14:0]    rsp_out_value,
   output logic [2:0]            rsp_error_code,
   output logic [6:0]            rsp_program_counter,
   output logic signed [14:0]    rsp_accumulator_out
);
   import dam_pkg::*;

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [PC_W-1:0] MEM_LIM = PC_W'(MEM_WORDS);

   localparam logic [6:0] OP_READ   = 7'd10;
   localparam logic [6:0] OP_WRITE  = 7'd11;
   localparam logic [6:0] OP_LOAD   = 7'd20;
   localparam logic [6:0] OP_STORE  = 7'd21;
   localparam logic [6:0] OP_ADD    = 7'd30;
   localparam logic [6:0] OP_SUB    = 7'd31;
   localparam logic [6:0] OP_DIV    = 7'd32;
   localparam logic [6:0] OP_MUL    = 7'd33;
   localparam logic [6:0] OP_REM    = 7'd34;
   localparam logic [6:0] OP_POW    = 7'd35;
   localparam logic [6:0] OP_BR     = 7'd40;
   localparam logic [6:0] OP_BRNEG  = 7'd41;
   localparam logic [6:0] OP_BRZERO = 7'd42;
   localparam logic [6:0] OP_HALT   = 7'd43;

   localparam logic [1:0] IT_DIV = 2'd0;
   localparam logic [1:0] IT_REM = 2'd1;
   localparam logic [1:0] IT_POW = 2'd2;

   localparam logic [3:0] DIV_STEPS_M1 = 4'(MAG_W - 1);

   function automatic logic oow30(input logic signed [29:0] v);
      return (v > 30'sd9999) || (v < -30'sd9999);
   endfunction

   function automatic logic [MAG_W-1:0] mag15(input logic signed [WORD_W-1:0] v);
      logic signed [WORD_W-1:0] a;
      a = v[WORD_W-1] ? -v : v;
      return a[MAG_W-1:0];
   endfunction

   // Captured request.
   logic [1:0]               cmd_ff;
   logic [PC_W-1:0]          adr_ff;
   logic signed [WORD_W-1:0] val_ff;

   // Architectural state.
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic signed [WORD_W-1:0] acc_ff, acc_in;
   logic                     halt_ff, halt_in;

   // Word memory with one valid bit per word.
   logic signed [WORD_W-1:0] word_mem [MEM_WORDS];
   logic [MEM_WORDS-1:0]     vld_ff;
   logic                     we, re;
   logic [AW-1:0]            wa, ra;
   logic signed [WORD_W-1:0] wd;
   logic signed [WORD_W-1:0] rd_ff;
   logic                     rv_ff;

   // Decode pipeline.
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [6:0]               opc_ff, opc_in;
   logic [6:0]               oa_ff, oa_in;
   logic [26:0]              dec_prod;
   logic [MAG_W-1:0]         hund;

   // Pending result.
   logic [1:0]               res_ev_ff, res_ev_in;
   logic signed [WORD_W-1:0] res_val_ff, res_val_in;
   logic [2:0]               res_err_ff, res_err_in;

   // Iterative divide and power unit.
   logic                     busy_ff, busy_in;
   logic [1:0]               mode_ff, mode_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic [MAG_W-1:0]         num_ff, num_in;
   logic [MAG_W-1:0]         rem_ff, rem_in;
   logic [MAG_W-1:0]         den_ff, den_in;
   logic signed [WORD_W-1:0] pw_ff, pw_in;
   logic                     qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [MAG_W:0]           trial;
   logic [MAG_W+1:0]         tdiff;
   logic [MAG_W-1:0]         rem_step, num_step;
   logic signed [WORD_W-1:0] q_word, r_word;

   logic signed [WORD_W-1:0] m_word, mul_b;
   logic signed [29:0]       prod;
   logic signed [WORD_W:0]   sum_w;
   logic                     oa_oob, uses;
   logic [2:0]               ex_err;
   logic                     ex_adv;

   assign oa_oob   = oa_ff >= MEM_LIM;
   assign m_word   = (rv_ff && !oa_oob) ? rd_ff : '0;
   assign mul_b    = (dp_op == DP_ITER) ? pw_ff : m_word;
   assign prod     = acc_ff * mul_b;
   assign dec_prod = mag_ff * 13'd5243;
   assign hund     = opc_ff * 7'd100;

   // One restoring division step.
   assign trial    = {rem_ff, num_ff[MAG_W-1]};
   assign tdiff    = {1'b0, trial} - {2'b00, den_ff};
   assign rem_step = tdiff[MAG_W+1] ? trial[MAG_W-1:0] : tdiff[MAG_W-1:0];
   assign num_step = {num_ff[MAG_W-2:0], !tdiff[MAG_W+1]};
   assign q_word   = qneg_ff ? -$signed({1'b0, num_step}) : $signed({1'b0, num_step});
   assign r_word   = rneg_ff ? -$signed({1'b0, rem_step}) : $signed({1'b0, rem_step});

   assign uses = (opc_ff == OP_READ) || (opc_ff == OP_WRITE) || (opc_ff == OP_LOAD) ||
                 (opc_ff == OP_STORE) || (opc_ff == OP_ADD) || (opc_ff == OP_SUB) ||
                 (opc_ff == OP_DIV) || (opc_ff == OP_MUL) || (opc_ff == OP_REM) ||
                 (opc_ff == OP_POW) || (opc_ff == OP_BR) || (opc_ff == OP_BRNEG) ||
                 (opc_ff == OP_BRZERO);

   always_comb begin
      pc_in      = pc_ff;
      acc_in     = acc_ff;
      halt_in    = halt_ff;
      mag_in     = mag_ff;
      opc_in     = opc_ff;
      oa_in      = oa_ff;
      res_ev_in  = res_ev_ff;
      res_val_in = res_val_ff;
      res_err_in = res_err_ff;
      busy_in    = busy_ff;
      mode_in    = mode_ff;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      pw_in      = pw_ff;
      qneg_in    = qneg_ff;
      rneg_in    = rneg_ff;
      we         = 1'b0;
      wa         = oa_ff[AW-1:0];
      wd         = acc_ff;
      re         = 1'b0;
      ra         = pc_ff[AW-1:0];
      sum_w      = '0;
      ex_err     = ERR_NONE;
      ex_adv     = 1'b0;
      unique case (dp_op)
         DP_DISPATCH: begin
            res_ev_in  = EV_NONE;
            res_val_in = '0;
            res_err_in = ERR_NONE;
            unique case (cmd_ff)
               CMD_LOAD: begin
                  wa = adr_ff[AW-1:0];
                  if (val_ff > 15'sd9999) begin
                     wd = 15'sd9999;
                  end else if (val_ff < -15'sd9999) begin
                     wd = -15'sd9999;
                  end else begin
                     wd = val_ff;
                  end
                  we = adr_ff < MEM_LIM;
               end
               CMD_RESTART: begin
                  pc_in   = '0;
                  halt_in = 1'b0;
               end
               CMD_STEP: begin
                  if (halt_ff) begin
                     res_ev_in = EV_HALT;
                  end else if (pc_ff >= MEM_LIM) begin
                     halt_in    = 1'b1;
                     res_ev_in  = EV_ERROR;
                     res_err_in = ERR_RANGE;
                  end else begin
                     re = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         DP_SPLIT: begin
            // A word never written since reset reads as zero.
            mag_in = mag15(rv_ff ? rd_ff : '0);
         end
         DP_DECODE: begin
            opc_in = dec_prod[25:19];
         end
         DP_ADDR: begin
            oa_in = 7'(mag_ff - hund);
         end
         DP_OPREAD: begin
            re = 1'b1;
            ra = oa_ff[AW-1:0];
         end
         DP_EXEC: begin
            res_ev_in  = EV_NONE;
            res_val_in = '0;
            res_err_in = ERR_NONE;
            if (uses && oa_oob) begin
               ex_err = ERR_RANGE;
            end else begin
               priority case (opc_ff)
                  OP_READ: begin
                     if (val_ff > 15'sd9999 || val_ff < -15'sd9999) begin
                        ex_err = ERR_OVERFLOW;
                     end else begin
                        we     = 1'b1;
                        wd     = val_ff;
                        ex_adv = 1'b1;
                     end
                  end
                  OP_WRITE: begin
                     ex_adv     = 1'b1;
                     res_ev_in  = EV_WRITE;
                     res_val_in = m_word;
                  end
                  OP_LOAD: begin
                     acc_in = m_word;
                     ex_adv = 1'b1;
                  end
                  OP_STORE: begin
                     we     = 1'b1;
                     ex_adv = 1'b1;
                  end
                  OP_ADD, OP_SUB: begin
                     if (opc_ff == OP_ADD) begin
                        sum_w = {acc_ff[WORD_W-1], acc_ff} + {m_word[WORD_W-1], m_word};
                     end else begin
                        sum_w = {acc_ff[WORD_W-1], acc_ff} - {m_word[WORD_W-1], m_word};
                     end
                     if (sum_w > 16'sd9999 || sum_w < -16'sd9999) begin
                        ex_err = ERR_OVERFLOW;
                     end else begin
                        acc_in = sum_w[WORD_W-1:0];
                        ex_adv = 1'b1;
                     end
                  end
                  OP_MUL: begin
                     if (oow30(prod)) begin
                        ex_err = ERR_OVERFLOW;
                     end else begin
                        acc_in = prod[WORD_W-1:0];
                        ex_adv = 1'b1;
                     end
                  end
                  OP_DIV, OP_REM: begin
                     if (m_word == '0) begin
                        ex_err = ERR_DIV_ZERO;
                     end else begin
                        busy_in = 1'b1;
                        mode_in = (opc_ff == OP_DIV) ? IT_DIV : IT_REM;
                        cnt_in  = DIV_STEPS_M1;
                        num_in  = mag15(acc_ff);
                        den_in  = mag15(m_word);
                        rem_in  = '0;
                        qneg_in = acc_ff[WORD_W-1] ^ m_word[WORD_W-1];
                        rneg_in = acc_ff[WORD_W-1];
                     end
                  end
                  OP_POW: begin
                     if (m_word < 0) begin
                        ex_err = ERR_NEG_EXP;
                     end else if (m_word == '0) begin
                        acc_in = 15'sd1;
                        ex_adv = 1'b1;
                     end else if (acc_ff == 15'sd0 || acc_ff == 15'sd1) begin
                        ex_adv = 1'b1;
                     end else if (acc_ff == -15'sd1) begin
                        acc_in = m_word[0] ? -15'sd1 : 15'sd1;
                        ex_adv = 1'b1;
                     end else begin
                        busy_in = 1'b1;
                        mode_in = IT_POW;
                        num_in  = m_word[MAG_W-1:0];
                        pw_in   = 15'sd1;
                     end
                  end
                  OP_BR: begin
                     pc_in = oa_ff;
                  end
                  OP_BRNEG: begin
                     if (acc_ff < 0) begin
                        pc_in = oa_ff;
                     end else begin
                        ex_adv = 1'b1;
                     end
                  end
                  OP_BRZERO: begin
                     if (acc_ff == '0) begin
                        pc_in = oa_ff;
                     end else begin
                        ex_adv = 1'b1;
                     end
                  end
                  OP_HALT: begin
                     halt_in   = 1'b1;
                     res_ev_in = EV_HALT;
                  end
                  default: begin
                     ex_err = ERR_OPCODE;
                  end
               endcase
            end
         end
         DP_ITER: begin
            if (mode_ff == IT_POW) begin
               if (oow30(prod)) begin
                  busy_in = 1'b0;
                  ex_err  = ERR_OVERFLOW;
               end else begin
                  pw_in  = prod[WORD_W-1:0];
                  num_in = num_ff - 1'b1;
                  if (num_ff == 14'd1) begin
                     busy_in = 1'b0;
                     acc_in  = prod[WORD_W-1:0];
                     ex_adv  = 1'b1;
                  end
               end
            end else begin
               num_in = num_step;
               rem_in = rem_step;
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  busy_in = 1'b0;
                  acc_in  = (mode_ff == IT_DIV) ? q_word : r_word;
                  ex_adv  = 1'b1;
               end
            end
         end
         DP_NOP, DP_CAPTURE, DP_PUBLISH: begin
         end
         default: begin
         end
      endcase
      if (ex_err != ERR_NONE) begin
         halt_in    = 1'b1;
         res_ev_in  = EV_ERROR;
         res_val_in = '0;
         res_err_in = ex_err;
      end else if (ex_adv) begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         acc_ff  <= '0;
         halt_ff <= 1'b0;
         busy_ff <= 1'b0;
         vld_ff  <= '0;
      end else begin
         pc_ff   <= pc_in;
         acc_ff  <= acc_in;
         halt_ff <= halt_in;
         busy_ff <= busy_in;
         if (we) begin
            vld_ff[wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         word_mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= word_mem[ra];
         rv_ff <= vld_ff[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_op == DP_CAPTURE) begin
         cmd_ff <= req_command;
         adr_ff <= req_address;
         val_ff <= req_value;
      end
      mag_ff     <= mag_in;
      opc_ff     <= opc_in;
      oa_ff      <= oa_in;
      res_ev_ff  <= res_ev_in;
      res_val_ff <= res_val_in;
      res_err_ff <= res_err_in;
      mode_ff    <= mode_in;
      cnt_ff     <= cnt_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      pw_ff      <= pw_in;
      qneg_ff    <= qneg_in;
      rneg_ff    <= rneg_in;
      if (dp_op == DP_PUBLISH) begin
         rsp_event_res       <= res_ev_ff;
         rsp_out_value       <= res_val_ff;
         rsp_error_code      <= res_err_ff;
         rsp_program_counter <= pc_ff;
         rsp_accumulator_out <= acc_ff;
      end
   end

   assign sts.cmd    = cmd_ff;
   assign sts.halted = halt_ff;
   assign sts.pc_oob = pc_ff >= MEM_LIM;
   assign sts.busy   = busy_ff;

endmodule

// File: hdl/decimal_accumulator_machine.sv
// Top level of the decimal accumulator machine: controller, datapath and checks.
//
// The block runs a small decimal program held in MEM_WORDS signed four-digit
// words. Each request beat carries a command: load one program word, execute
// one instruction, or restart at pc zero. Every request beat produces exactly
// one response beat with an event code, the value of a write instruction, an
// error code, and the pc and accumulator after the command.
// Both channels use valid and ready. A request is taken only while the block
// is idle, so one command is in flight at a time; a finished response waits in
// the output register, and the block already accepts the next request then.
// Fetch, decode, operand read and execute of an instruction are sequenced by
// the controller over one memory read port; load and restart skip them.
// Divide and remainder iterate with one quotient bit per cycle over 14 bits,
// and exponent with one multiplication per cycle.
// If the receiver stalls, the next response waits in the final state until the
// output register is free. Synchronous reset clears the memory valid bits (so
// every word reads as zero), the pc, accumulator and halted flag, and both
// channels' handshake state.
module decimal_accumulator_machine #(
   parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [6:0]         req_address,
   input  logic signed [14:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_event_res,
   output logic signed [14:0] rsp_out_value,
   output logic [2:0]         rsp_error_code,
   output logic [6:0]         rsp_program_counter,
   output logic signed [14:0] rsp_accumulator_out
);
   import dam_pkg::*;

   // Command from the controller and status from the datapath.
   dam_dpop_type dp_op;
   dam_sts_type  sts;

   dam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .dp_op     (dp_op)
   );

   dam_dp #(
      .MEM_WORDS (MEM_WORDS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .dp_op               (dp_op),
      .req_command         (req_command),
      .req_address         (req_address),
      .req_value           (req_value),
      .sts                 (sts),
      .rsp_event_res       (rsp_event_res),
      .rsp_out_value       (rsp_out_value),
      .rsp_error_code      (rsp_error_code),
      .rsp_program_counter (rsp_program_counter),
      .rsp_accumulator_out (rsp_accumulator_out)
   );

   // Only one command is in flight: an accepted beat closes the request side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a command was in flight");

   // An error code travels only with an error event.
   a_err_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_res == EV_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code and event disagree");

   // Only a write instruction carries an output value.
   a_out_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != EV_WRITE) |-> (rsp_out_value == '0))
      else $error("output value outside a write event");

   // The accumulator never leaves the four-digit range.
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accumulator_out <= 15'sd9999 && rsp_accumulator_out >= -15'sd9999))
      else $error("accumulator out of range");

endmodule
